>>> src/assert_macros.svh
// assertion macros included by the url percent decoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/upd_pkg.sv
// types, character codes and hex helper for the url percent decoder
package upd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned NIB_W  = 5;

  // escape phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  // character codes
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h66;
  localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;

  localparam logic [NIB_W-1:0] NOT_HEX       = 5'd16;
  localparam logic [NIB_W-1:0] HEX_ALPHA_OFS = 5'd10;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'hFFFF;

  // decoder state carried from word to word
  typedef struct packed {
    logic [1:0]       phase;
    logic [NIB_W-1:0] high_nib;
    logic [LEN_W-1:0] count;
  } upd_state_t;

  // what one input word produces
  typedef struct packed {
    logic              have_result;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              end_of_string;
    logic [LEN_W-1:0]  decoded_length;
  } upd_result_t;

  // value of one hex digit, NOT_HEX for anything else
  function automatic logic [NIB_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] diff;
    begin
      diff = '0;
      if (c >= CH_0 && c <= CH_9) begin
        diff = c - CH_0;
        hex_value = diff[NIB_W-1:0];
      end else if (c >= CH_LA && c <= CH_LF) begin
        diff = c - CH_LA;
        hex_value = diff[NIB_W-1:0] + HEX_ALPHA_OFS;
      end else if (c >= CH_UA && c <= CH_UF) begin
        diff = c - CH_UA;
        hex_value = diff[NIB_W-1:0] + HEX_ALPHA_OFS;
      end else begin
        hex_value = NOT_HEX;
      end
    end
  endfunction

endpackage

>>> src/upd_if.sv
// handshake channels of the url percent decoder

// encoded character channel
interface upd_in_if
  import upd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              last;

  modport source (output valid, output in_byte, output last, input ready);
  modport sink   (input valid, input in_byte, input last, output ready);
endinterface

// decoded result channel
interface upd_out_if
  import upd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              end_of_string;
  logic [LEN_W-1:0]  decoded_length;

  modport source (output valid, output out_byte, output byte_valid,
                  output end_of_string, output decoded_length, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input end_of_string, input decoded_length, output ready);
endinterface

// configuration write channel for the length limit
interface upd_cfg_if
  import upd_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] max_output_length;

  modport source (output valid, output max_output_length, input ready);
  modport sink   (input valid, input max_output_length, output ready);
endinterface

>>> src/upd_decode.sv
// per-character decode step: next state and result from one word
module upd_decode
  import upd_pkg::*;
(
  input  upd_state_t        state_cur,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              last,
  input  logic [LEN_W-1:0]  max_len,
  output upd_state_t        state_nxt,
  output upd_result_t       result
);

  logic [NIB_W-1:0]  lo_nib;
  logic              have;
  logic [BYTE_W-1:0] emit;
  logic [LEN_W-1:0]  count_upd;
  upd_state_t        st;
  logic [BYTE_W-1:0] joined;

  assign lo_nib = hex_value(in_byte);
  assign joined = {state_cur.high_nib[3:0], lo_nib[3:0]};

  // escape tracking and byte selection
  always_comb begin
    st   = state_cur;
    have = 1'b0;
    emit = '0;
    if (state_cur.count < max_len) begin
      case (state_cur.phase)
        PH_PCT: begin
          if (last) begin
            st.phase = PH_IDLE;
            // percent right before the end: last byte is plain, no new escape
            if (in_byte == CH_PLUS) begin
              have = 1'b1;
              emit = CH_SPACE;
            end else if (in_byte != CH_PCT) begin
              have = 1'b1;
              emit = in_byte;
            end
          end else begin
            st.high_nib = hex_value(in_byte);
            st.phase    = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          st.phase    = PH_IDLE;
          st.high_nib = '0;
          if (state_cur.high_nib != NOT_HEX && lo_nib != NOT_HEX) begin
            have = 1'b1;
            emit = joined;
          end
        end
        default: begin
          st.phase = PH_IDLE;
          if (in_byte == CH_PLUS) begin
            have = 1'b1;
            emit = CH_SPACE;
          end else if (in_byte == CH_PCT) begin
            if (!last) begin
              st.phase = PH_PCT;
            end
          end else begin
            have = 1'b1;
            emit = in_byte;
          end
        end
      endcase
    end
  end

  assign count_upd = have ? state_cur.count + 16'd1 : state_cur.count;

  // result word and end-of-string clear
  always_comb begin
    state_nxt       = st;
    state_nxt.count = count_upd;
    if (last) begin
      state_nxt = '0;
    end
    result.have_result    = have | last;
    result.out_byte       = have ? emit : '0;
    result.byte_valid     = have;
    result.end_of_string  = last;
    result.decoded_length = last ? count_upd : '0;
  end

endmodule

>>> src/url_percent_decoder.sv
// url percent decoder top level: input register, decode step, result register
// a character waits in the input register until the result register is free
// one character per cycle unless the result register stalls; decode state is registered
// a stalled result register holds its word while the input register still fills
// characters that produce no result leave no word on the output channel
// synchronous active-low reset clears control, decode state and sets limit to 65535
`include "assert_macros.svh"

module url_percent_decoder
  import upd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  upd_in_if.sink    in_chan,
  upd_out_if.source out_chan,
  upd_cfg_if.sink   cfg_chan
);

  logic              s1_v_r, s1_v_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              out_v_r, out_v_nxt;
  upd_result_t       out_r;
  upd_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]  max_len_r;
  upd_result_t       result;
  logic              out_free;
  logic              s1_fire;
  logic              in_fire;

  // handshake control
  assign out_free = !out_v_r || out_chan.ready;
  assign s1_fire  = s1_v_r && out_free;
  assign in_chan.ready = !s1_v_r || out_free;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign s1_v_nxt = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_v_r);
  assign out_v_nxt = out_free ? (s1_v_r && result.have_result) : out_v_r;

  // config write always taken
  assign cfg_chan.ready = 1'b1;

  // decode step
  upd_decode u_decode (
    .state_cur (state_r),
    .in_byte   (s1_byte_r),
    .last      (s1_last_r),
    .max_len   (max_len_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      state_r   <= '0;
      max_len_r <= MAX_LEN_RESET;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s1_fire) begin
        state_r <= state_nxt;
      end
      if (cfg_chan.valid) begin
        max_len_r <= cfg_chan.max_output_length;
      end
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_chan.in_byte;
      s1_last_r <= in_chan.last;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (s1_fire && result.have_result) begin
      out_r <= result;
    end
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.out_byte       = out_r.out_byte;
  assign out_chan.byte_valid     = out_r.byte_valid;
  assign out_chan.end_of_string  = out_r.end_of_string;
  assign out_chan.decoded_length = out_r.decoded_length;

  // checks on the decode logic
  `ASSERT_IMPL(a_word_has_content, out_v_r, out_r.byte_valid || out_r.end_of_string, "empty result word")
  `ASSERT_IMPL(a_len_only_at_end, out_v_r && !out_r.end_of_string, out_r.decoded_length == '0, "length off end")
  `ASSERT_IMPL(a_byte_zero_if_none, out_v_r && !out_r.byte_valid, out_r.out_byte == '0, "stray byte")
  `ASSERT_NEXT(a_clear_after_last, s1_fire && s1_last_r, state_r == '0, "state not cleared")

endmodule

>>> verif/tb_url_percent_decoder.sv
// testbench for the url percent decoder: directed and random strings checked by a scoreboard
module tb_url_percent_decoder
  import upd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT     = 200000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LONG_HOLD     = 250;
  localparam int unsigned PHASE_CHARS   = 115;

  // one decoded result word as seen on the output channel
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              end_of_string;
    logic [LEN_W-1:0]  decoded_length;
  } decoded_word_t;

  // decoder predictor and queue of expected result words
  class decode_scoreboard;
    logic [LEN_W-1:0] max_len;
    logic [1:0]       phase;
    logic [NIB_W-1:0] high_nib;
    logic [LEN_W-1:0] count;
    decoded_word_t    expected_q[$];
    int unsigned      errors;
    int unsigned      words_checked;
    int unsigned      strings_done;

    function new();
      max_len       = MAX_LEN_RESET;
      phase         = PH_IDLE;
      high_nib      = '0;
      count         = '0;
      errors        = 0;
      words_checked = 0;
      strings_done  = 0;
    endfunction

    // nibble value of a hex digit, NOT_HEX otherwise
    function logic [NIB_W-1:0] digit_value(logic [BYTE_W-1:0] c);
      if (c >= CH_0 && c <= CH_9) return NIB_W'(c - CH_0);
      if (c >= CH_LA && c <= CH_LF) return NIB_W'(c - CH_LA) + HEX_ALPHA_OFS;
      if (c >= CH_UA && c <= CH_UF) return NIB_W'(c - CH_UA) + HEX_ALPHA_OFS;
      return NOT_HEX;
    endfunction

    // character outside an escape; a percent opens one unless it ends the string
    function bit plain_char(logic [BYTE_W-1:0] c, bit is_last,
                            output logic [BYTE_W-1:0] emit);
      emit = c;
      if (c == CH_PLUS) begin
        emit = CH_SPACE;
      end else if (c == CH_PCT) begin
        if (!is_last) phase = PH_PCT;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // accepted input character: advance the decoder and queue any result
    function void note_char(logic [BYTE_W-1:0] c, bit is_last);
      bit               have;
      logic [BYTE_W-1:0] emit;
      logic [NIB_W-1:0] low_nib;
      decoded_word_t    w;
      have = 1'b0;
      emit = '0;
      if (count < max_len) begin
        case (phase)
          PH_PCT: begin
            if (is_last) begin
              phase = PH_IDLE;
              have  = plain_char(c, 1'b1, emit);
            end else begin
              high_nib = digit_value(c);
              phase    = PH_DIGIT;
            end
          end
          PH_DIGIT: begin
            low_nib = digit_value(c);
            phase   = PH_IDLE;
            if (high_nib != NOT_HEX && low_nib != NOT_HEX) begin
              emit = {high_nib[3:0], low_nib[3:0]};
              have = 1'b1;
            end
            high_nib = '0;
          end
          default: begin
            phase = PH_IDLE;
            have  = plain_char(c, is_last, emit);
          end
        endcase
      end
      if (have) count = count + 1'b1;
      if (have || is_last) begin
        w.out_byte       = have ? emit : '0;
        w.byte_valid     = have;
        w.end_of_string  = is_last;
        w.decoded_length = is_last ? count : '0;
        expected_q.push_back(w);
      end
      // string end clears the decode state, the limit stays
      if (is_last) begin
        phase    = PH_IDLE;
        high_nib = '0;
        count    = '0;
        strings_done++;
      end
    endfunction

    function void flag(string what, decoded_word_t want, decoded_word_t got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch %0d (%s): expected byte %02h bv %0b eos %0b len %0d, got byte %02h bv %0b eos %0b len %0d",
                 errors, what, want.out_byte, want.byte_valid, want.end_of_string,
                 want.decoded_length, got.out_byte, got.byte_valid, got.end_of_string,
                 got.decoded_length);
    endfunction

    // accepted result word: compare against the oldest expectation
    function void check_word(decoded_word_t got);
      decoded_word_t want;
      string         bad;
      words_checked++;
      if (expected_q.size() == 0) begin
        flag("no word expected", '0, got);
        return;
      end
      want = expected_q.pop_front();
      bad  = "";
      if (got.out_byte !== want.out_byte) bad = {bad, " out_byte"};
      if (got.byte_valid !== want.byte_valid) bad = {bad, " byte_valid"};
      if (got.end_of_string !== want.end_of_string) bad = {bad, " end_of_string"};
      if (got.decoded_length !== want.decoded_length) bad = {bad, " decoded_length"};
      if (bad != "") flag({"field", bad}, want, got);
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  upd_in_if  in_ch();
  upd_out_if out_ch();
  upd_cfg_if cfg_ch();

  url_percent_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  decode_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_left     = 0;
  int unsigned chars_sent    = 0;
  int unsigned cycle_count   = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // result side: check accepted words, random stalls and the long hold-off
  initial begin
    decoded_word_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.out_byte       = out_ch.out_byte;
        got.byte_valid     = out_ch.byte_valid;
        got.end_of_string  = out_ch.end_of_string;
        got.decoded_length = out_ch.decoded_length;
        sb.check_word(got);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one character, with random gaps before it
  task automatic send_char(input logic [BYTE_W-1:0] c, input bit is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= c;
    in_ch.last    <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_char(c, is_last);
    chars_sent++;
  endtask

  task automatic send_list(input logic [BYTE_W-1:0] s[$]);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  // sender pauses until every expected word has come and the pipe is empty
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.max_output_length <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.max_len = v;
  endtask

  function automatic logic [BYTE_W-1:0] hex_char();
    int unsigned k;
    k = $urandom_range(21);
    if (k < 10) return CH_0 + 8'(k);
    if (k < 16) return CH_LA + 8'(k - 10);
    return CH_UA + 8'(k - 16);
  endfunction

  // any nonzero byte that is not a hex digit
  function automatic logic [BYTE_W-1:0] other_char();
    logic [BYTE_W-1:0] c;
    do c = 8'($urandom_range(1, 255)); while (sb.digit_value(c) != NOT_HEX);
    return c;
  endfunction

  // string of random bytes, pluses and well-formed escapes, with broken escapes and noise mixed in
  task automatic send_random_string(input int unsigned n_tokens);
    logic [BYTE_W-1:0] s[$];
    int unsigned       r;
    for (int t = 0; t < n_tokens; t++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        s.push_back(8'($urandom_range(1, 255)));
      end else if (r < 42) begin
        s.push_back(CH_PLUS);
      end else if (r < 75) begin
        s.push_back(CH_PCT);
        s.push_back(hex_char());
        s.push_back(hex_char());
      end else if (r < 83) begin
        s.push_back(CH_PCT);
        s.push_back(other_char());
        s.push_back(hex_char());
      end else if (r < 90) begin
        s.push_back(CH_PCT);
        s.push_back(hex_char());
        s.push_back(other_char());
      end else if (r < 95) begin
        s.push_back(CH_PCT);
      end else begin
        s.push_back(other_char());
      end
    end
    // sometimes the string ends inside an escape
    r = $urandom_range(9);
    if (r == 0) begin
      s.push_back(CH_PCT);
    end else if (r == 1) begin
      s.push_back(CH_PCT);
      s.push_back(8'($urandom_range(1, 255)));
    end
    send_list(s);
  endtask

  // one setting of limit, idling and stalling, random strings until enough characters went in
  task automatic run_phase(input logic [LEN_W-1:0] limit, input int unsigned idle,
                           input int unsigned stall, input bit long_hold,
                           input bit mid_pause);
    int unsigned first;
    wait_drained();
    write_limit(limit);
    send_idle_pct = idle;
    stall_pct     = stall;
    if (long_hold) hold_left = LONG_HOLD;
    first = chars_sent;
    while (chars_sent - first < PHASE_CHARS) begin
      if (mid_pause && chars_sent - first >= PHASE_CHARS / 2) begin
        wait_drained();
        mid_pause = 1'b0;
      end
      if ($urandom_range(9) == 0) send_random_string($urandom_range(10, 30));
      else send_random_string($urandom_range(1, 8));
    end
    // close the phase with a complete string
    send_char(CH_PLUS, 1'b1);
  endtask

  // main sequence
  initial begin
    logic [BYTE_W-1:0] dq[$];
    in_ch.valid              = 1'b0;
    in_ch.in_byte            = '0;
    in_ch.last               = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.max_output_length = MAX_LEN_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed strings at the reset limit
    dq = '{CH_PLUS, 8'hFF, 8'h01, CH_PCT, "4", "1", CH_PCT, "f", "F", CH_PCT, "0", "0"};
    send_list(dq);
    // broken escapes on either digit
    dq = '{CH_PCT, "g", "1", CH_PCT, "2", "Z", "~"};
    send_list(dq);
    // percent as the last character
    dq = '{CH_PCT};
    send_list(dq);
    // percent then the last character, plus and percent
    dq = '{CH_PCT, CH_PLUS};
    send_list(dq);
    dq = '{CH_PCT, CH_PCT};
    send_list(dq);

    run_phase(MAX_LEN_RESET, 0, 0, 1'b1, 1'b0);
    run_phase(16'd1, 63, 0, 1'b0, 1'b0);
    run_phase(16'd4, 0, 63, 1'b0, 1'b0);
    run_phase(MAX_LEN_RESET, 20, 20, 1'b0, 1'b1);
    run_phase(16'($urandom_range(2, 12)), 63, 63, 1'b0, 1'b0);
    run_phase(16'd2, 0, 0, 1'b0, 1'b0);

    // drain and let the pipe settle
    in_ch.valid <= 1'b0;
    stall_pct = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d characters in %0d strings, %0d result words checked, %0d cycles",
             chars_sent, sb.strings_done, sb.words_checked, cycle_count);
    $display("limits 1 to 65535, all idle modes, long output hold-off, %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
